FILE: design/rectangle_outline_fill_raster_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef RECTANGLE_OUTLINE_FILL_RASTER_UNIT_MACROS_SVH
`define RECTANGLE_OUTLINE_FILL_RASTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ROFR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ROFR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rofr_pkg.sv
package rofr_pkg;

   localparam int MaxSide  = 256;
   localparam int IdxW     = $clog2(MaxSide);
   localparam int SideW    = IdxW + 1;
   localparam int AddrW    = 2 * IdxW;
   localparam int CharW    = 8;
   localparam int TypeW    = 8;
   localparam int FixW     = 18;
   localparam int FracW    = 8;
   localparam int CoordW   = FixW + 2;
   localparam int CmdW     = 2;
   localparam int CsrDataW = 32;
   localparam int CsrAddrW = 4;
   localparam int CsrIdxW  = 2;

   localparam logic [TypeW-1:0] TYPE_FILLED  = 8'd82;
   localparam logic [TypeW-1:0] TYPE_OUTLINE = 8'd114;

   localparam logic [SideW-1:0] DIM_RESET = SideW'(MaxSide);
   localparam logic [CharW-1:0] BG_RESET  = 8'd32;

   localparam logic [CsrIdxW-1:0] REG_CANVAS_WIDTH  = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_CANVAS_HEIGHT = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_BACKGROUND    = 2'd2;

   typedef enum logic [CmdW-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [SideW-1:0] width;
      logic [SideW-1:0] height;
      logic [CharW-1:0] background;
   } cfg_type;

   typedef struct packed {
      logic hit;
      logic band;
   } band_type;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      logic [CharW-1:0] data;
   } canvas_wr_type;

endpackage

FILE: design/rofr_channels.sv
interface rofr_req_if;
   logic                                valid;
   logic                                ready;
   logic        [rofr_pkg::CmdW-1:0]    cmd;
   logic        [rofr_pkg::TypeW-1:0]   rect_type;
   logic signed [rofr_pkg::FixW-1:0]    pos_x;
   logic signed [rofr_pkg::FixW-1:0]    pos_y;
   logic signed [rofr_pkg::FixW-1:0]    size_w;
   logic signed [rofr_pkg::FixW-1:0]    size_h;
   logic        [rofr_pkg::CharW-1:0]   draw_char;
   logic        [rofr_pkg::IdxW-1:0]    read_col;
   logic        [rofr_pkg::IdxW-1:0]    read_row;

   modport source (
      output valid, cmd, rect_type, pos_x, pos_y, size_w, size_h, draw_char,
             read_col, read_row,
      input  ready
   );
   modport sink (
      input  valid, cmd, rect_type, pos_x, pos_y, size_w, size_h, draw_char,
             read_col, read_row,
      output ready
   );
endinterface

interface rofr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [rofr_pkg::CharW-1:0]   cell_char;

   modport source (output valid, status, cell_char, input ready);
   modport sink (input valid, status, cell_char, output ready);
endinterface

FILE: design/rofr_band_unit.sv
module rofr_band_unit (
   input  logic signed [rofr_pkg::CoordW-1:0] point,
   input  logic signed [rofr_pkg::CoordW-1:0] lo,
   input  logic signed [rofr_pkg::CoordW-1:0] hi,
   output rofr_pkg::band_type                 result
);
   import rofr_pkg::*;

   localparam logic signed [CoordW-1:0] OneQ = CoordW'(1 << FracW);

   logic signed [CoordW-1:0] from_lo;
   logic signed [CoordW-1:0] to_hi;

   assign from_lo     = point - lo;
   assign to_hi       = hi - point;
   assign result.hit  = (point >= lo) && (point <= hi);
   assign result.band = (from_lo < OneQ) || (to_hi < OneQ);

endmodule

FILE: design/rofr_canvas_mem.sv
module rofr_canvas_mem (
   input  logic                          clock,
   input  rofr_pkg::canvas_wr_type       wr,
   input  logic                          rd_en,
   input  logic [rofr_pkg::AddrW-1:0]    rd_addr,
   output logic [rofr_pkg::CharW-1:0]    rd_data
);
   import rofr_pkg::*;

   logic [CharW-1:0] mem [(1 << AddrW)];
   logic [CharW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rofr_csr.sv
module rofr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rofr_pkg::CsrAddrW-1:0]   paddr,
   input  logic [rofr_pkg::CsrDataW-1:0]   pwdata,
   output logic [rofr_pkg::CsrDataW-1:0]   prdata,
   output rofr_pkg::cfg_type               cfg
);
   import rofr_pkg::*;

   logic [SideW-1:0]   width_ff;
   logic [SideW-1:0]   height_ff;
   logic [CharW-1:0]   bg_ff;
   logic [CsrIdxW-1:0] idx;
   logic               wr_en;

   assign idx   = paddr[CsrAddrW-1:2];
   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         bg_ff     <= BG_RESET;
      end else if (wr_en) begin
         if (idx == REG_CANVAS_WIDTH) begin
            width_ff <= pwdata[SideW-1:0];
         end
         if (idx == REG_CANVAS_HEIGHT) begin
            height_ff <= pwdata[SideW-1:0];
         end
         if (idx == REG_BACKGROUND) begin
            bg_ff <= pwdata[CharW-1:0];
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_CANVAS_WIDTH:  prdata = CsrDataW'(width_ff);
         REG_CANVAS_HEIGHT: prdata = CsrDataW'(height_ff);
         REG_BACKGROUND:    prdata = CsrDataW'(bg_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.width      = width_ff;
   assign cfg.height     = height_ff;
   assign cfg.background = bg_ff;

endmodule

FILE: design/rectangle_outline_fill_raster_unit.sv
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    cmd, rect_type, pos_x, pos_y, size_w, size_h, draw_char,
//                              read_col, read_row
// rsp_ch   out  valid/ready    status, cell_char
// csr_*    in   APB write      canvas_width, canvas_height, background_char
//
// Clear: writes the background char to every canvas entry, one canvas write per cycle through the single write port.
// Draw: steps through the canvas columns, and through every row of each column that meets
//   the rectangle; a rejected draw writes nothing and goes straight to the response.
// Read: registered canvas read.
// req ready is low from acceptance until the result enters the output register;
//   a result held by a stalled rsp_ch does not block acceptance of the next request.
// Synchronous reset clears control and configuration; the canvas is not cleared.
module rectangle_outline_fill_raster_unit (
   input  logic                            clock,
   input  logic                            reset,
   rofr_req_if.sink                        req_ch,
   rofr_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rofr_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [rofr_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [rofr_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready
);
   import rofr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_COL,
      ST_ROW,
      ST_READ,
      ST_DONE
   } state_type;

   cfg_type          cfg;
   logic [SideW-1:0] eff_w;
   logic [SideW-1:0] eff_h;

   state_type                 state_ff,      state_in;
   logic [SideW-1:0]          col_ff,        col_in;
   logic [SideW-1:0]          row_ff,        row_in;
   logic [AddrW-1:0]          clr_addr_ff,   clr_addr_in;
   logic signed [CoordW-1:0]  lo_x_ff,       lo_x_in;
   logic signed [CoordW-1:0]  hi_x_ff,       hi_x_in;
   logic signed [CoordW-1:0]  lo_y_ff,       lo_y_in;
   logic signed [CoordW-1:0]  hi_y_ff,       hi_y_in;
   logic                      filled_ff,     filled_in;
   logic [CharW-1:0]          char_ff,       char_in;
   logic                      kx_band_ff,    kx_band_in;
   logic                      in_canvas_ff,  in_canvas_in;
   logic                      res_status_ff, res_status_in;
   logic [CharW-1:0]          res_cell_ff,   res_cell_in;
   logic                      rsp_valid_ff,  rsp_valid_in;
   logic                      rsp_status_ff, rsp_status_in;
   logic [CharW-1:0]          rsp_cell_ff,   rsp_cell_in;

   canvas_wr_type             wr;
   logic                      rd_en;
   logic [CharW-1:0]          rd_data;

   logic [IdxW-1:0]           unit_idx;
   logic signed [CoordW-1:0]  unit_point;
   logic signed [CoordW-1:0]  unit_lo;
   logic signed [CoordW-1:0]  unit_hi;
   band_type                  unit_res;
   logic                      row_phase;
   logic                      reject;

   rofr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   assign eff_w = (cfg.width  > DIM_RESET) ? DIM_RESET : cfg.width;
   assign eff_h = (cfg.height > DIM_RESET) ? DIM_RESET : cfg.height;

   rofr_canvas_mem u_canvas (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr ({req_ch.read_row, req_ch.read_col}),
      .rd_data (rd_data)
   );

   assign row_phase  = (state_ff == ST_ROW);
   assign unit_idx   = row_phase ? row_ff[IdxW-1:0] : col_ff[IdxW-1:0];
   assign unit_point = $signed({{(CoordW-IdxW-FracW){1'b0}}, unit_idx, {FracW{1'b0}}});
   assign unit_lo    = row_phase ? lo_y_ff : lo_x_ff;
   assign unit_hi    = row_phase ? hi_y_ff : hi_x_ff;

   rofr_band_unit u_band (
      .point  (unit_point),
      .lo     (unit_lo),
      .hi     (unit_hi),
      .result (unit_res)
   );

   assign reject = (req_ch.size_w <= 0) || (req_ch.size_h <= 0)
                || ((req_ch.rect_type != TYPE_FILLED) && (req_ch.rect_type != TYPE_OUTLINE));

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.cell_char = rsp_cell_ff;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      clr_addr_in   = clr_addr_ff;
      lo_x_in       = lo_x_ff;
      hi_x_in       = hi_x_ff;
      lo_y_in       = lo_y_ff;
      hi_y_in       = hi_y_ff;
      filled_in     = filled_ff;
      char_in       = char_ff;
      kx_band_in    = kx_band_ff;
      in_canvas_in  = in_canvas_ff;
      res_status_in = res_status_ff;
      res_cell_in   = res_cell_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cell_in   = rsp_cell_ff;
      wr            = '0;
      rd_en         = 1'b0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               rd_en         = 1'b1;
               res_status_in = 1'b0;
               res_cell_in   = '0;
               unique case (cmd_type'(req_ch.cmd))
                  CMD_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_DRAW: begin
                     if (reject) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else begin
                        lo_x_in   = CoordW'(req_ch.pos_x);
                        hi_x_in   = CoordW'(req_ch.pos_x) + CoordW'(req_ch.size_w);
                        lo_y_in   = CoordW'(req_ch.pos_y);
                        hi_y_in   = CoordW'(req_ch.pos_y) + CoordW'(req_ch.size_h);
                        filled_in = (req_ch.rect_type == TYPE_FILLED);
                        char_in   = req_ch.draw_char;
                        col_in    = '0;
                        state_in  = ST_COL;
                     end
                  end
                  CMD_READ: begin
                     in_canvas_in = ({1'b0, req_ch.read_col} < eff_w)
                                 && ({1'b0, req_ch.read_row} < eff_h);
                     state_in     = ST_READ;
                  end
                  CMD_NOP: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            wr.en       = 1'b1;
            wr.addr     = clr_addr_ff;
            wr.data     = cfg.background;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_COL: begin
            if (col_ff >= eff_w) begin
               state_in = ST_DONE;
            end else if (unit_res.hit) begin
               kx_band_in = unit_res.band;
               row_in     = '0;
               state_in   = ST_ROW;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_ROW: begin
            if (row_ff >= eff_h) begin
               col_in   = col_ff + 1'b1;
               state_in = ST_COL;
            end else begin
               if (unit_res.hit && (kx_band_ff || unit_res.band || filled_ff)) begin
                  wr.en   = 1'b1;
                  wr.addr = {row_ff[IdxW-1:0], col_ff[IdxW-1:0]};
                  wr.data = char_ff;
               end
               row_in = row_ff + 1'b1;
            end
         end
         ST_READ: begin
            res_cell_in = in_canvas_ff ? rd_data : '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cell_in   = res_cell_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff        <= col_in;
      row_ff        <= row_in;
      clr_addr_ff   <= clr_addr_in;
      lo_x_ff       <= lo_x_in;
      hi_x_ff       <= hi_x_in;
      lo_y_ff       <= lo_y_in;
      hi_y_ff       <= hi_y_in;
      filled_ff     <= filled_in;
      char_ff       <= char_in;
      kx_band_ff    <= kx_band_in;
      in_canvas_ff  <= in_canvas_in;
      res_status_ff <= res_status_in;
      res_cell_ff   <= res_cell_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cell_ff   <= rsp_cell_in;
   end

endmodule

FILE: design/rofr_checker.sv
`include "rectangle_outline_fill_raster_unit_macros.svh"

module rofr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic [rofr_pkg::CharW-1:0]   rsp_cell_char,
   input logic                         csr_pready
);
   import rofr_pkg::*;

   `ROFR_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_cell_char), "rsp transaction changed while stalled")
   `ROFR_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready high right after a req transaction")
   `ROFR_ASSERT_IMP(a_reject_no_char, rsp_valid && rsp_status, rsp_cell_char == '0, "rejected draw carries a character")
   `ROFR_ASSERT_IMP(a_csr_ready, 1'b1, csr_pready, "csr pready dropped")

endmodule

bind rectangle_outline_fill_raster_unit rofr_checker u_rofr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_cell_char (rsp_ch.cell_char),
   .csr_pready    (csr_pready)
);
